// ----- hdl/pshash_pkg.sv -----
`timescale 1ns / 1ps
package pshash_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = 5;
    localparam int PID_W   = 5;
    localparam int LIVE_W  = $clog2(SLOTS + 1);
    localparam int PID_TOP = SLOTS - 1;

    localparam logic [PID_W-1:0]  PID_TOP_V   = PID_W'(PID_TOP);
    localparam logic [PID_W-1:0]  PID_FIRST   = PID_W'(1);
    localparam logic [PID_W-1:0]  LAST_CAND   = PID_W'(PID_TOP - 1);
    localparam logic [SLOT_W-1:0] LAST_STEP   = SLOT_W'(SLOTS - 1);
    localparam logic [LIVE_W-1:0] LIVE_LIMIT  = LIVE_W'(SLOTS);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NOTLIVE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2,
        TAG_RSVD  = 2'd3
    } tag_t;

    typedef struct packed {
        logic start;
        logic run;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_busy;
    } stat_t;

    // home slot: pid mod (SLOTS-1); a 5-bit pid stays below twice the modulus
    function automatic logic [SLOT_W-1:0] home_slot(input logic [PID_W-1:0] p);
        logic [PID_W-1:0] r;
        begin
            r = (p >= PID_TOP_V) ? (p - PID_TOP_V) : p;
            return SLOT_W'(r);
        end
    endfunction

    function automatic logic [PID_W-1:0] next_cand(input logic [PID_W-1:0] p);
        begin
            return (p >= PID_TOP_V) ? PID_FIRST : (p + PID_FIRST);
        end
    endfunction

endpackage

// ----- hdl/pshash_ctrl.sv -----
`timescale 1ns / 1ps
module pshash_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pshash_pkg::stat_t     stat,
    output pshash_pkg::cmd_t      cmd
);
    import pshash_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (stat.done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.start    = (state_reg == S_IDLE) && in_valid;
    assign cmd.run      = (state_reg == S_RUN);
    assign cmd.load_out = (state_reg == S_RESP) && !stat.out_busy;

`ifndef NO_ASSERTIONS
    a_run_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cmd.run)
        else $error("request accepted but no run followed");
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.run, cmd.load_out}))
        else $error("controller issued overlapping commands");
    a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> in_ready)
        else $error("controller not idle after result load");
`endif

endmodule

// ----- hdl/pshash_dp.sv -----
`timescale 1ns / 1ps
module pshash_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pshash_pkg::cmd_t              cmd,
    output pshash_pkg::stat_t             stat,
    input  logic [1:0]                    op,
    input  logic [pshash_pkg::PID_W-1:0]  pid,
    input  logic [pshash_pkg::SLOT_W-1:0] slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [pshash_pkg::SLOT_W-1:0] found_slot,
    output logic [pshash_pkg::PID_W-1:0]  new_pid
);
    import pshash_pkg::*;

    tag_t              tag_reg [SLOTS];
    logic [PID_W-1:0]  pid_arr_reg [SLOTS];

    op_t               op_reg;
    logic [PID_W-1:0]  cand_reg, cand_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0] step_reg, step_next;
    logic [PID_W-1:0]  ncand_reg, ncand_next;
    logic              tomb_vld_reg, tomb_vld_next;
    logic [SLOT_W-1:0] tomb_reg, tomb_next;
    logic [LIVE_W-1:0] live_reg, live_next;
    logic [PID_W-1:0]  next_pid_reg, next_pid_next;

    status_t           res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [PID_W-1:0]  res_pid_reg, res_pid_next;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [PID_W-1:0]  out_pid_reg;

    tag_t              rd_tag;
    logic [PID_W-1:0]  rd_pid;
    logic              pid_hit;
    logic              last_step;
    logic              done;
    logic              tbl_we;
    logic [SLOT_W-1:0] wr_addr;
    tag_t              wr_tag;
    logic [PID_W-1:0]  wr_pid;
    logic [PID_W-1:0]  start_cand;

    assign rd_tag    = tag_reg[ptr_reg];
    assign rd_pid    = pid_arr_reg[ptr_reg];
    assign pid_hit   = (rd_tag == TAG_LIVE) && (rd_pid == cand_reg);
    assign last_step = (step_reg == LAST_STEP);
    assign start_cand = (next_pid_reg == '0) ? PID_FIRST : next_pid_reg;

    always_comb
    begin
        cand_next       = cand_reg;
        ptr_next        = ptr_reg;
        step_next       = step_reg;
        ncand_next      = ncand_reg;
        tomb_vld_next   = tomb_vld_reg;
        tomb_next       = tomb_reg;
        live_next       = live_reg;
        next_pid_next   = next_pid_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_pid_next    = res_pid_reg;
        done            = 1'b0;
        tbl_we          = 1'b0;
        wr_addr         = ptr_reg;
        wr_tag          = TAG_LIVE;
        wr_pid          = cand_reg;

        if (cmd.run)
        begin
            res_status_next = ST_OK;
            res_slot_next   = '0;
            res_pid_next    = '0;
            case (op_reg)
                OP_ALLOC:
                begin
                    if (live_reg >= LIVE_LIMIT)
                    begin
                        done            = 1'b1;
                        res_status_next = ST_FULL;
                    end
                    else if (pid_hit)
                    begin
                        // candidate in use: restart the probe with the next pid
                        if (ncand_reg == LAST_CAND)
                        begin
                            done            = 1'b1;
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            cand_next     = next_cand(cand_reg);
                            ptr_next      = home_slot(next_cand(cand_reg));
                            step_next     = '0;
                            ncand_next    = ncand_reg + PID_W'(1);
                            tomb_vld_next = 1'b0;
                        end
                    end
                    else if (rd_tag == TAG_EMPTY || last_step)
                    begin
                        done = 1'b1;
                        if (tomb_vld_reg || rd_tag == TAG_EMPTY || rd_tag == TAG_TOMB)
                        begin
                            tbl_we          = 1'b1;
                            wr_addr         = tomb_vld_reg ? tomb_reg : ptr_reg;
                            live_next       = live_reg + LIVE_W'(1);
                            next_pid_next   = next_cand(cand_reg);
                            res_slot_next   = wr_addr;
                            res_pid_next    = cand_reg;
                        end
                        else
                            res_status_next = ST_FULL;
                    end
                    else
                    begin
                        if (rd_tag == TAG_TOMB && !tomb_vld_reg)
                        begin
                            tomb_vld_next = 1'b1;
                            tomb_next     = ptr_reg;
                        end
                        ptr_next  = ptr_reg + SLOT_W'(1);
                        step_next = step_reg + SLOT_W'(1);
                    end
                end
                OP_LOOKUP:
                begin
                    if (pid_hit)
                    begin
                        done          = 1'b1;
                        res_slot_next = ptr_reg;
                    end
                    else if (rd_tag == TAG_EMPTY || last_step)
                    begin
                        done            = 1'b1;
                        res_status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        ptr_next  = ptr_reg + SLOT_W'(1);
                        step_next = step_reg + SLOT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    done = 1'b1;
                    if (rd_tag == TAG_LIVE)
                    begin
                        tbl_we    = 1'b1;
                        wr_tag    = TAG_TOMB;
                        wr_pid    = '0;
                        live_next = (live_reg != '0) ? (live_reg - LIVE_W'(1)) : live_reg;
                    end
                    else
                        res_status_next = ST_NOTLIVE;
                end
                default:
                    done = 1'b1;
            endcase
        end
    end

    assign stat.done     = done;
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                tag_reg[i] <= TAG_EMPTY;
            live_reg      <= '0;
            next_pid_reg  <= PID_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tbl_we)
                tag_reg[wr_addr] <= wr_tag;
            live_reg     <= live_next;
            next_pid_reg <= next_pid_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            pid_arr_reg[wr_addr] <= wr_pid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg       <= op_t'(op);
            step_reg     <= '0;
            ncand_reg    <= '0;
            tomb_vld_reg <= 1'b0;
            if (op_t'(op) == OP_ALLOC)
            begin
                cand_reg <= start_cand;
                ptr_reg  <= home_slot(start_cand);
            end
            else if (op_t'(op) == OP_REMOVE)
            begin
                cand_reg <= pid;
                ptr_reg  <= slot;
            end
            else
            begin
                cand_reg <= pid;
                ptr_reg  <= home_slot(pid);
            end
        end
        else
        begin
            cand_reg     <= cand_next;
            ptr_reg      <= ptr_next;
            step_reg     <= step_next;
            ncand_reg    <= ncand_next;
            tomb_vld_reg <= tomb_vld_next;
        end
        tomb_reg       <= tomb_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_pid_reg    <= res_pid_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_pid_reg    <= res_pid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found_slot = out_slot_reg;
    assign new_pid    = out_pid_reg;

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_W'(PID_TOP))
        else $error("live count above number of pids");
    a_next_pid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        next_pid_reg != '0)
        else $error("next pid register holds zero");
    a_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> cmd.run && done)
        else $error("table written outside the final probe step");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");
`endif

endmodule

// ----- hdl/pid_slot_hash_table_top.sv -----
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_ready  op, pid, slot
// out      out_valid/ out_ready status, found_slot, new_pid
//
// One table entry is examined per cycle, and the probe walk sets how long a request runs:
// remove reads only the given slot, an unused op examines none, lookup walks up to SLOTS entries,
// and allocate restarts the walk for each candidate pid that is already live.
// Reset marks every slot empty, clears the live count and sets the next pid to 1.
// A new request is taken while a finished result waits in the output register; a stalled
// output holds the next result in the datapath until the register frees.
module pid_slot_hash_table_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    op,
    input  logic [pshash_pkg::PID_W-1:0]  pid,
    input  logic [pshash_pkg::SLOT_W-1:0] slot,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [pshash_pkg::SLOT_W-1:0] found_slot,
    output logic [pshash_pkg::PID_W-1:0]  new_pid
);
    import pshash_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pshash_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pshash_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .pid        (pid),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found_slot (found_slot),
        .new_pid    (new_pid)
    );

endmodule
